// File: src/bppd_pkg.sv
package bppd_pkg;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MAX_COL_BYTES = (MAX_HEIGHT + 7) / 8;
   localparam int STORE_DEPTH   = MAX_WIDTH * MAX_COL_BYTES;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   localparam int DIM_W   = 11;
   localparam int COORD_W = 10;
   localparam int POS_W   = 19;
   localparam int LINE_W  = 11;
   localparam int BIL_W   = 7;
   localparam int LEN_W   = 8;

   localparam logic [POS_W-1:0]  POS_MAX  = '1;
   localparam logic [LINE_W-1:0] LINE_MAX = '1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_BIT_MODE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_MODE    = 2'd3;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd480;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd800;

   typedef struct packed {
      logic               pixels;
      logic               two_bit;
      logic [7:0]         data;
      logic [7:0]         plane1;
      logic [COORD_W-1:0] fixed;
      logic [COORD_W-1:0] base;
      logic [2:0]         last;
      logic               dark;
      logic               error;
   } item_type;

endpackage

// File: src/bitplane_page_pixel_decoder.sv
// the first result of a byte is offered once the byte has passed the pending
// register and then the output register
// each byte gives 1 to 8 results; the output stage gives one result per cycle while
// rsp_ready is high, and the plane memory port is not limiting
// reset: registers return to their defaults, counters and the error flag clear,
// the plane memory keeps its contents and needs no clearing pass
module bitplane_page_pixel_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_page_byte,
   input  logic                               req_page_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_pixel_valid,
   output logic [bppd_pkg::COORD_W-1:0]       rsp_pixel_x,
   output logic [bppd_pkg::COORD_W-1:0]       rsp_pixel_y,
   output logic                               rsp_ink_black,
   output logic [1:0]                         rsp_gray_level,
   output logic                               rsp_lsb_mark,
   output logic                               rsp_msb_mark,
   output logic                               rsp_page_error,
   output logic                               rsp_run_last,
   input  logic                               csr_write_en,
   input  logic [bppd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bppd_pkg::DIM_W-1:0]         csr_wdata
);

   localparam int DIM_W   = bppd_pkg::DIM_W;
   localparam int COORD_W = bppd_pkg::COORD_W;
   localparam int POS_W   = bppd_pkg::POS_W;
   localparam int LINE_W  = bppd_pkg::LINE_W;
   localparam int BIL_W   = bppd_pkg::BIL_W;
   localparam int LEN_W   = bppd_pkg::LEN_W;
   localparam int ADDR_W  = bppd_pkg::ADDR_W;
   localparam int PROD_W  = COORD_W + LEN_W;

   logic [DIM_W-1:0]  page_width_ff;
   logic [DIM_W-1:0]  page_height_ff;
   logic              two_bit_mode_ff;
   logic              dark_mode_ff;

   logic [POS_W-1:0]  byte_position_ff;
   logic [LINE_W-1:0] line_index_ff;
   logic [BIL_W-1:0]  byte_in_line_ff;
   logic              error_seen_ff;

   logic [POS_W-1:0]  byte_position_in;
   logic [LINE_W-1:0] line_index_in;
   logic [BIL_W-1:0]  byte_in_line_in;
   logic              error_seen_in;

   bppd_pkg::item_type pend_ff, pend_in;
   bppd_pkg::item_type emit_ff, emit_in;
   logic               pend_valid_ff;
   logic               emit_valid_ff;
   logic [2:0]         emit_cnt_ff;

   logic [DIM_W-1:0]   w_eff, h_eff, px_limit, remain;
   logic [LEN_W-1:0]   row_bytes, col_bytes, line_limit, bil_inc;
   logic [POS_W-1:0]   plane_size;
   logic [POS_W-1:0]   pos0;
   logic [LINE_W-1:0]  line0;
   logic [BIL_W-1:0]   bil0;
   logic               err0;
   logic [COORD_W-1:0] base;
   logic               has_px;
   logic               step, count;
   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [7:0]         ram_rd_data;

   logic accept, pend_move, rsp_done;

   assign rsp_done  = rsp_valid && rsp_ready && rsp_run_last;
   assign pend_move = pend_valid_ff && (!emit_valid_ff || rsp_done);
   assign req_ready = !pend_valid_ff || pend_move;
   assign accept    = req_valid && req_ready;

   assign w_eff = (page_width_ff > DIM_W'(bppd_pkg::MAX_WIDTH)) ?
                  DIM_W'(bppd_pkg::MAX_WIDTH) : page_width_ff;
   assign h_eff = (page_height_ff > DIM_W'(bppd_pkg::MAX_HEIGHT)) ?
                  DIM_W'(bppd_pkg::MAX_HEIGHT) : page_height_ff;
   assign row_bytes  = LEN_W'((w_eff + DIM_W'(7)) >> 3);
   assign col_bytes  = LEN_W'((h_eff + DIM_W'(7)) >> 3);
   assign plane_size = POS_W'(w_eff) * POS_W'(col_bytes);

   assign pos0  = req_page_start ? '0 : byte_position_ff;
   assign line0 = req_page_start ? '0 : line_index_ff;
   assign bil0  = req_page_start ? '0 : byte_in_line_ff;
   assign err0  = req_page_start ? 1'b0 : error_seen_ff;

   assign base     = {bil0, 3'b000};
   assign px_limit = two_bit_mode_ff ? h_eff : w_eff;
   assign has_px   = px_limit > DIM_W'(base);
   assign remain   = px_limit - DIM_W'(base);
   assign ram_rd_addr = ADDR_W'(PROD_W'(line0[COORD_W-1:0]) * PROD_W'(col_bytes)
                                + PROD_W'(bil0));
   assign line_limit = two_bit_mode_ff ? col_bytes : row_bytes;
   assign bil_inc    = LEN_W'(bil0) + LEN_W'(1);

   always_comb begin
      error_seen_in = err0;
      step    = 1'b0;
      count   = 1'b0;
      ram_we  = 1'b0;
      ram_re  = 1'b0;
      pend_in = '0;
      if (w_eff == '0 || h_eff == '0) begin
         error_seen_in = 1'b1;
      end else if (!err0) begin
         if (!two_bit_mode_ff) begin
            if (line0 >= h_eff) begin
               error_seen_in = 1'b1;
            end else begin
               pend_in.pixels = has_px;
               pend_in.fixed  = line0[COORD_W-1:0];
               step  = 1'b1;
               count = 1'b1;
            end
         end else if (pos0 < plane_size) begin
            ram_we = 1'b1;
            count  = 1'b1;
         end else if (line0 >= w_eff) begin
            error_seen_in = 1'b1;
         end else begin
            ram_re          = accept;
            pend_in.pixels  = has_px;
            pend_in.two_bit = 1'b1;
            pend_in.fixed   = COORD_W'(w_eff - DIM_W'(1) - line0);
            step  = 1'b1;
            count = 1'b1;
         end
      end
      pend_in.data  = req_page_byte;
      pend_in.base  = base;
      pend_in.dark  = dark_mode_ff;
      pend_in.error = error_seen_in;
      if (pend_in.pixels) begin
         pend_in.last = (remain >= DIM_W'(8)) ? 3'd7 : 3'(remain - DIM_W'(1));
      end

      byte_position_in = pos0;
      if (count && pos0 < bppd_pkg::POS_MAX) begin
         byte_position_in = pos0 + POS_W'(1);
      end
      line_index_in   = line0;
      byte_in_line_in = bil0;
      if (step) begin
         if (bil_inc >= line_limit) begin
            byte_in_line_in = '0;
            if (line0 < bppd_pkg::LINE_MAX) begin
               line_index_in = line0 + LINE_W'(1);
            end
         end else begin
            byte_in_line_in = BIL_W'(bil_inc);
         end
      end
   end

   bppd_ram #(
      .WIDTH (8),
      .DEPTH (bppd_pkg::STORE_DEPTH)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (accept && ram_we),
      .wr_addr (ADDR_W'(pos0)),
      .wr_data (req_page_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_width_ff    <= bppd_pkg::RESET_WIDTH;
         page_height_ff   <= bppd_pkg::RESET_HEIGHT;
         two_bit_mode_ff  <= 1'b0;
         dark_mode_ff     <= 1'b0;
         byte_position_ff <= '0;
         line_index_ff    <= '0;
         byte_in_line_ff  <= '0;
         error_seen_ff    <= 1'b0;
         pend_valid_ff    <= 1'b0;
         emit_valid_ff    <= 1'b0;
         emit_cnt_ff      <= '0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               bppd_pkg::CSR_PAGE_WIDTH:   page_width_ff   <= csr_wdata;
               bppd_pkg::CSR_PAGE_HEIGHT:  page_height_ff  <= csr_wdata;
               bppd_pkg::CSR_TWO_BIT_MODE: two_bit_mode_ff <= csr_wdata[0];
               bppd_pkg::CSR_DARK_MODE:    dark_mode_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept) begin
            byte_position_ff <= byte_position_in;
            line_index_ff    <= line_index_in;
            byte_in_line_ff  <= byte_in_line_in;
            error_seen_ff    <= error_seen_in;
            pend_valid_ff    <= 1'b1;
         end else if (pend_move) begin
            pend_valid_ff <= 1'b0;
         end
         if (pend_move) begin
            emit_valid_ff <= 1'b1;
            emit_cnt_ff   <= '0;
         end else if (rsp_done) begin
            emit_valid_ff <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            emit_cnt_ff <= emit_cnt_ff + 3'd1;
         end
      end
   end

   always_comb begin
      emit_in        = pend_ff;
      emit_in.plane1 = ram_rd_data;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         emit_ff <= emit_in;
      end
   end

   logic [2:0]         sel;
   logic               b1, b2, blk;
   logic [COORD_W-1:0] run_pos;

   assign sel     = 3'd7 - emit_cnt_ff;
   assign b1      = emit_ff.plane1[sel];
   assign b2      = emit_ff.data[sel];
   assign blk     = ~b2;
   assign run_pos = emit_ff.base + COORD_W'(emit_cnt_ff);

   assign rsp_valid      = emit_valid_ff;
   assign rsp_page_error = emit_ff.error;
   assign rsp_run_last   = (emit_cnt_ff == emit_ff.last);

   always_comb begin
      rsp_pixel_valid = emit_ff.pixels;
      rsp_pixel_x     = '0;
      rsp_pixel_y     = '0;
      rsp_ink_black   = 1'b0;
      rsp_gray_level  = 2'd0;
      rsp_lsb_mark    = 1'b0;
      rsp_msb_mark    = 1'b0;
      if (emit_ff.pixels) begin
         if (emit_ff.two_bit) begin
            rsp_pixel_x    = emit_ff.fixed;
            rsp_pixel_y    = run_pos;
            rsp_ink_black  = (b1 | b2) ^ emit_ff.dark;
            rsp_gray_level = {b1, b2};
            rsp_lsb_mark   = b2 & ~b1;
            rsp_msb_mark   = b1 ^ b2;
         end else begin
            rsp_pixel_x    = run_pos;
            rsp_pixel_y    = emit_ff.fixed;
            rsp_ink_black  = blk ^ emit_ff.dark;
            rsp_gray_level = {blk, blk};
         end
      end
   end

`ifndef ASSERT_OFF
   a_nopix_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pixel_valid) |-> rsp_run_last)
      else $error("result without pixel is not the last of its byte");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      emit_valid_ff |-> (emit_cnt_ff <= emit_ff.last))
      else $error("result counter ran past the byte's pixel count");

   a_pend_drains: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !emit_valid_ff) |=> emit_valid_ff)
      else $error("pending transaction did not move to the output stage");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> (rsp_valid && emit_cnt_ff != '0))
      else $error("results of a byte stopped before its last one");
`endif

endmodule

// File: src/bppd_ram.sv
module bppd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tb_bitplane_page_pixel_decoder.sv
module tb_bitplane_page_pixel_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int COORD_W     = bppd_pkg::COORD_W;
   localparam int DIM_W       = bppd_pkg::DIM_W;
   localparam int CSR_IDX_W   = bppd_pkg::CSR_IDX_W;
   localparam int ADDR_W      = bppd_pkg::ADDR_W;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } page_item_type;

   typedef struct packed {
      logic               pixel_valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               ink;
      logic [1:0]         gray;
      logic               lsb;
      logic               msb;
      logic               err;
      logic               last;
   } pixel_result_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_page_byte = '0;
   logic               req_page_start = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_pixel_valid;
   logic [COORD_W-1:0] rsp_pixel_x;
   logic [COORD_W-1:0] rsp_pixel_y;
   logic               rsp_ink_black;
   logic [1:0]         rsp_gray_level;
   logic               rsp_lsb_mark;
   logic               rsp_msb_mark;
   logic               rsp_page_error;
   logic               rsp_run_last;
   logic               csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]   csr_wdata = '0;

   page_item_type    page_byte_q[$];
   pixel_result_type pixel_expect_q[$];

   // register mirror
   int cfg_width   = int'(bppd_pkg::RESET_WIDTH);
   int cfg_height  = int'(bppd_pkg::RESET_HEIGHT);
   bit cfg_two_bit = 1'b0;
   bit cfg_dark    = 1'b0;

   // decoder state mirror
   int dec_pos  = 0;
   int dec_line = 0;
   int dec_slot = 0;
   bit dec_err  = 1'b0;
   logic [7:0] plane_mem [0:bppd_pkg::STORE_DEPTH-1];

   int fail_count     = 0;
   int pixels_checked = 0;
   int cycle_count    = 0;
   int tx_gap         = 0;
   int rx_stall       = 0;
   bit calm           = 1'b0;
   bit long_hold_done = 1'b0;

   bitplane_page_pixel_decoder uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 70) return 0;
      if (r < 95) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 30));
   endfunction

   function automatic void next_byte_slot(input int span);
      dec_slot++;
      if (dec_slot >= span) begin
         dec_slot = 0;
         if (dec_line < int'(bppd_pkg::LINE_MAX)) dec_line++;
      end
   endfunction

   // expected pixel writes for one accepted page byte
   function automatic void decode_page_byte(input logic [7:0] data, input logic start);
      pixel_result_type run[$];
      pixel_result_type r;
      int w, h, span, plane, x, y;
      logic [7:0] p1;
      logic b1, b2, black;
      if (start) begin
         dec_pos  = 0;
         dec_line = 0;
         dec_slot = 0;
         dec_err  = 1'b0;
      end
      w = (cfg_width > bppd_pkg::MAX_WIDTH) ? bppd_pkg::MAX_WIDTH : cfg_width;
      h = (cfg_height > bppd_pkg::MAX_HEIGHT) ? bppd_pkg::MAX_HEIGHT : cfg_height;
      if (w == 0 || h == 0) begin
         dec_err = 1'b1;
      end else if (!dec_err) begin
         if (!cfg_two_bit) begin
            span = (w + 7) / 8;
            if (dec_line >= h) begin
               dec_err = 1'b1;
            end else begin
               for (int k = 0; k < 8; k++) begin
                  x = dec_slot * 8 + k;
                  if (x < w) begin
                     black = ~data[3'(7 - k)];
                     r = '0;
                     r.pixel_valid = 1'b1;
                     r.x = COORD_W'(x);
                     r.y = COORD_W'(dec_line);
                     r.ink = black ^ cfg_dark;
                     r.gray = black ? 2'd3 : 2'd0;
                     run.push_back(r);
                  end
               end
               next_byte_slot(span);
            end
         end else begin
            span = (h + 7) / 8;
            plane = w * span;
            if (dec_pos < plane) begin
               plane_mem[ADDR_W'(dec_pos)] = data;
            end else if (dec_line >= w) begin
               dec_err = 1'b1;
            end else begin
               p1 = plane_mem[ADDR_W'(dec_line * span + dec_slot)];
               x = w - 1 - dec_line;
               for (int k = 0; k < 8; k++) begin
                  y = dec_slot * 8 + k;
                  if (y < h) begin
                     b1 = p1[3'(7 - k)];
                     b2 = data[3'(7 - k)];
                     r = '0;
                     r.pixel_valid = 1'b1;
                     r.x = COORD_W'(x);
                     r.y = COORD_W'(y);
                     r.ink = (b1 | b2) ^ cfg_dark;
                     r.gray = {b1, b2};
                     r.lsb = b2 & ~b1;
                     r.msb = b1 ^ b2;
                     run.push_back(r);
                  end
               end
               next_byte_slot(span);
            end
         end
         if (!dec_err && dec_pos < int'(bppd_pkg::POS_MAX)) dec_pos++;
      end
      if (run.size() == 0) begin
         r = '0;
         run.push_back(r);
      end
      foreach (run[k]) begin
         run[k].err = dec_err;
         run[k].last = (k == run.size() - 1);
         pixel_expect_q.push_back(run[k]);
      end
   endfunction

   function automatic void check_field(input string field, input logic [COORD_W-1:0] want,
                                       input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   // sender
   always @(posedge clock) begin : tx_side
      page_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) decode_page_byte(req_page_byte, req_page_start);
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (page_byte_q.size() > 0) begin
               nxt = page_byte_q.pop_front();
               req_valid <= 1'b1;
               req_page_byte <= nxt.data;
               req_page_start <= nxt.start;
               tx_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : rx_side
      pixel_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_expect_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual x=%0d y=%0d",
                        $time, rsp_pixel_x, rsp_pixel_y);
               fail_count++;
            end else begin
               want = pixel_expect_q.pop_front();
               check_field("pixel_valid", COORD_W'(want.pixel_valid),
                           COORD_W'(rsp_pixel_valid));
               check_field("pixel_x", want.x, rsp_pixel_x);
               check_field("pixel_y", want.y, rsp_pixel_y);
               check_field("ink_black", COORD_W'(want.ink), COORD_W'(rsp_ink_black));
               check_field("gray_level", COORD_W'(want.gray), COORD_W'(rsp_gray_level));
               check_field("lsb_mark", COORD_W'(want.lsb), COORD_W'(rsp_lsb_mark));
               check_field("msb_mark", COORD_W'(want.msb), COORD_W'(rsp_msb_mark));
               check_field("page_error", COORD_W'(want.err), COORD_W'(rsp_page_error));
               check_field("run_last", COORD_W'(want.last), COORD_W'(rsp_run_last));
            end
            pixels_checked++;
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && pixels_checked > 150 && page_byte_q.size() > 10) begin
            // long hold so the block backs up into its input
            long_hold_done = 1'b1;
            rx_stall = 400;
            rsp_ready <= 1'b0;
         end else begin
            rx_stall = pick_gap();
            rsp_ready <= (rx_stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic wait_drained();
      while (page_byte_q.size() != 0 || req_valid || pixel_expect_q.size() != 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[DIM_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input int w, input int h, input bit two, input bit dark);
      wait_drained();
      write_csr(bppd_pkg::CSR_PAGE_WIDTH, w);
      write_csr(bppd_pkg::CSR_PAGE_HEIGHT, h);
      write_csr(bppd_pkg::CSR_TWO_BIT_MODE, int'(two));
      write_csr(bppd_pkg::CSR_DARK_MODE, int'(dark));
      cfg_width = w & 'h7FF;
      cfg_height = h & 'h7FF;
      cfg_two_bit = two;
      cfg_dark = dark;
   endtask

   function automatic void push_byte(input logic [7:0] data, input logic start);
      page_item_type it;
      it.data = data;
      it.start = start;
      page_byte_q.push_back(it);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic int page_length();
      int w, h;
      w = (cfg_width > bppd_pkg::MAX_WIDTH) ? bppd_pkg::MAX_WIDTH : cfg_width;
      h = (cfg_height > bppd_pkg::MAX_HEIGHT) ? bppd_pkg::MAX_HEIGHT : cfg_height;
      if (w == 0 || h == 0) return 1;
      if (cfg_two_bit) return 2 * w * ((h + 7) / 8);
      return ((w + 7) / 8) * h;
   endfunction

   // page bytes, with a rare stray page_start inside
   function automatic void queue_page(input int len, input bit first);
      for (int k = 0; k < len; k++)
         push_byte(rand_byte(), (k == 0) ? first : ($urandom_range(0, 79) == 0));
   endfunction

   initial begin
      logic [47:0] plane1_bytes;
      logic [47:0] plane2_bytes;
      int w, h, full, len, kind, npages, stim_count;
      bit two, big, first;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default registers, start of a wide page
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);

      // partial byte at row end, row wrap, overrun then restart
      configure(10, 2, 1'b0, 1'b1);
      push_byte(8'h80, 1'b1);
      push_byte(8'h01, 1'b0);
      push_byte(8'hA5, 1'b0);
      push_byte(8'h3C, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h7E, 1'b1);

      // zero width, zero height
      configure(0, 1, 1'b0, 1'b0);
      push_byte(8'h12, 1'b1);
      push_byte(8'h34, 1'b0);
      configure(5, 0, 1'b0, 1'b0);
      push_byte(8'h56, 1'b1);

      // oversize registers are clamped
      configure(2047, 2047, 1'b0, 1'b0);
      push_byte(8'hC3, 1'b1);
      push_byte(8'h99, 1'b0);

      // grayscale page with every plane combination, then overrun
      configure(3, 9, 1'b1, 1'b0);
      plane1_bytes = {8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0};
      plane2_bytes = {8'hFF, 8'h00, 8'h55, 8'hAA, 8'h33, 8'hCC};
      for (int k = 0; k < 6; k++) push_byte(plane1_bytes[6'(47 - 8 * k) -: 8], k == 0);
      for (int k = 0; k < 6; k++) push_byte(plane2_bytes[6'(47 - 8 * k) -: 8], 1'b0);
      push_byte(8'h5A, 1'b0);

      stim_count = 0;
      while (stim_count < 400) begin
         wait_drained();
         calm = ($urandom_range(0, 3) == 0);
         big = ($urandom_range(0, 9) == 0);
         two = 1'($urandom_range(0, 1));
         if (!big) begin
            w = int'($urandom_range(1, 16));
            h = int'($urandom_range(1, 16));
         end else if (!two) begin
            w = int'($urandom_range(0, 1) ? 2047 : $urandom_range(17, 1024));
            h = int'($urandom_range(0, 1) ? 2047 : $urandom_range(17, 1024));
         end else begin
            w = int'($urandom_range(1, 2));
            h = int'($urandom_range(0, 1) ? 2047 : $urandom_range(100, 1024));
         end
         configure(w, h, two, 1'($urandom_range(0, 1)));
         npages = big ? 1 : int'($urandom_range(1, 3));
         for (int p = 0; p < npages; p++) begin
            full = page_length();
            kind = big ? 0 : int'($urandom_range(0, 9));
            if (kind < 7) len = full;
            else if (kind == 7) len = int'($urandom_range(1, full));
            else if (kind == 8) len = full + int'($urandom_range(1, 3));
            else len = int'($urandom_range(1, 4));
            if (big) len = two ? (full / 2 + 8) : 30;
            // a first one-bit page may continue from old counters, a first grayscale page always restarts
            if (p == 0) first = two || ($urandom_range(0, 2) != 0);
            else first = (kind != 9);
            queue_page(len, first);
            stim_count += (kind == 8) ? full : len;
         end
      end

      calm = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/bppd_pkg.sv
src/bppd_ram.sv
src/bitplane_page_pixel_decoder.sv
test/tb_bitplane_page_pixel_decoder.sv
